// ===== rtl/swpd_pkg.sv =====
// Shared constants and the pixel color decode for the screen word pixel decoder.
`default_nettype none

package swpd_pkg;

  // Register map: word index on the configuration port
  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_REFRESH_OFF = 2'd1;
  localparam logic [1:0] REG_DEBUG_HOLD  = 2'd2;

  localparam int unsigned PADDR_W = 4;

  // Mode register bits
  localparam int unsigned MODE_BANK_BIT  = 7;
  localparam int unsigned MODE_EIGHT_BIT = 3;
  localparam int unsigned MODE_BLANK_BIT = 1;

  // Start of the upper screen bank
  localparam logic [17:0] BANK_SPLIT = 18'h28000;

  localparam int unsigned PIX_PER_WORD = 8;
  localparam int unsigned PIX_IDX_W    = 3;

  // Per-pixel color bits of one word, bit i is pixel i
  typedef struct packed {
    logic [PIX_PER_WORD-1:0] red;
    logic [PIX_PER_WORD-1:0] green;
    logic [PIX_PER_WORD-1:0] blue;
  } pix_colors_t;

  // Decode the eight pixels of one screen word
  function automatic pix_colors_t decode_colors(input logic [15:0] w, input logic eight,
                                                input logic blank);
    pix_colors_t c;
    int unsigned p2;
    for (int unsigned i = 0; i < PIX_PER_WORD; i++) begin
      p2 = i & 32'hfffffffe;
      if (!eight) begin
        c.green[i] = w[15-i];
        c.red[i]   = w[7-i];
        c.blue[i]  = w[15-i] & w[7-i];
      end else begin
        c.green[i] = w[15-p2];
        c.red[i]   = w[7-p2];
        c.blue[i]  = w[6-p2];
      end
      if (blank) begin
        c.green[i] = 1'b0;
        c.red[i]   = 1'b0;
        c.blue[i]  = 1'b0;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/screen_word_pixel_decoder.sv =====
// Screen word pixel decoder: filters screen writes and streams eight pixels per word.
// A kept word passes the input and filter/decode registers, then its eight pixels leave
// the pixel serializer one pixel per cycle on the result port while out_ready allows;
// the serializer takes the next word as its last pixel loads. A dropped word leaves at stage 1.
// Pipeline: input register, filter/decode register, pixel serializer, output register.
// Reset (rst_n low, synchronous): all stages empty, mode/refresh_off/debug_hold = 0.
`default_nettype none

module screen_word_pixel_decoder
  import swpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input words
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [17:0]        in_write_address,
  input  wire logic [15:0]        in_write_word,
  // pixel results
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [8:0]              out_pixel_x,
  output logic [7:0]              out_pixel_y,
  output logic                    out_pixel_red,
  output logic                    out_pixel_green,
  output logic                    out_pixel_blue,
  output logic                    out_pixel_last,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // ---------------- configuration registers ----------------
  logic [7:0] mode_r;
  logic       refresh_off_r;
  logic       debug_hold_r;
  logic [1:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= '0;
      refresh_off_r <= 1'b0;
      debug_hold_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE:        mode_r        <= pwdata[7:0];
        REG_REFRESH_OFF: refresh_off_r <= pwdata[0];
        REG_DEBUG_HOLD:  debug_hold_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_MODE:        prdata = {24'd0, mode_r};
      REG_REFRESH_OFF: prdata = {31'd0, refresh_off_r};
      REG_DEBUG_HOLD:  prdata = {31'd0, debug_hold_r};
      default:         prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic              s1_v_r, s1_v_nxt;
  logic [17:0]       s1_addr_r;
  logic [15:0]       s1_word_r;

  logic              s2_v_r, s2_v_nxt;
  logic [7:0]        s2_row_r;
  logic [8:0]        s2_xbase_r;
  pix_colors_t       s2_col_r;

  logic              ser_v_r, ser_v_nxt;
  logic [PIX_IDX_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]        ser_row_r;
  logic [8:0]        ser_xbase_r;
  pix_colors_t       ser_col_r;

  logic              out_v_r, out_v_nxt;

  logic in_acc, keep, bank_hi, s1_done, s1_fwd, s2_free, s2_adv;
  logic out_ld, ser_done, ser_free;

  // stage 1 filter: refresh, debugger hold and screen bank
  assign bank_hi = (s1_addr_r >= BANK_SPLIT);
  assign keep    = !refresh_off_r && !debug_hold_r && (mode_r[MODE_BANK_BIT] == bank_hi);

  // handshake chain, back to front
  assign out_ld   = ser_v_r && (!out_v_r || out_ready);
  assign ser_done = out_ld && (cnt_r == PIX_IDX_W'(PIX_PER_WORD - 1));
  assign ser_free = !ser_v_r || ser_done;
  assign s2_adv   = s2_v_r && ser_free;
  assign s2_free  = !s2_v_r || s2_adv;
  assign s1_fwd   = s1_v_r && keep && s2_free;
  assign s1_done  = s1_v_r && (!keep || s2_free);
  assign in_ready = !s1_v_r || s1_done;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_v_nxt  = in_acc ? 1'b1 : (s1_done ? 1'b0 : s1_v_r);
    s2_v_nxt  = s1_fwd ? 1'b1 : (s2_adv ? 1'b0 : s2_v_r);
    ser_v_nxt = s2_adv ? 1'b1 : (ser_done ? 1'b0 : ser_v_r);
    out_v_nxt = out_ld ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
    if (s2_adv) begin
      cnt_nxt = '0;
    end else if (out_ld) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      ser_v_r <= 1'b0;
      out_v_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      ser_v_r <= ser_v_nxt;
      out_v_r <= out_v_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // ---------------- datapath ----------------
  // stage 1: input word register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr_r <= in_write_address;
      s1_word_r <= in_write_word;
    end
  end

  // stage 2: row, base x and per-pixel colors
  always_ff @(posedge clk) begin
    if (s1_fwd) begin
      s2_row_r   <= s1_addr_r[14:7];
      s2_xbase_r <= {s1_addr_r[6:0], 2'b00};
      s2_col_r   <= decode_colors(s1_word_r, mode_r[MODE_EIGHT_BIT], mode_r[MODE_BLANK_BIT]);
    end
  end

  // stage 3: serializer holds the word while its pixels drain
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      ser_row_r   <= s2_row_r;
      ser_xbase_r <= s2_xbase_r;
      ser_col_r   <= s2_col_r;
    end
  end

  // output register, one pixel of the serialized word per load
  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_pixel_x     <= ser_xbase_r + {6'd0, cnt_r};
      out_pixel_y     <= ser_row_r;
      out_pixel_red   <= ser_col_r.red[cnt_r];
      out_pixel_green <= ser_col_r.green[cnt_r];
      out_pixel_blue  <= ser_col_r.blue[cnt_r];
      out_pixel_last  <= (cnt_r == PIX_IDX_W'(PIX_PER_WORD - 1));
    end
  end

  assign out_valid = out_v_r;

endmodule

`default_nettype wire
